FILE: rtl/task_slot_scheduler_core_assert.svh
// Assertion macros shared by the scheduler's checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef TASK_SLOT_SCHEDULER_CORE_ASSERT_SVH
`define TASK_SLOT_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

FILE: rtl/tss_pkg.sv
`default_nettype none

package tss_pkg;

  // Sizing of the scheduler.
  localparam int TASK_SLOTS   = 512;
  localparam int POP_ATTEMPTS = 16;

  // Field widths of the ports.
  localparam int SLOT_W = 9;
  localparam int LIVE_W = 10;

  // The status table packs ROW_SLOTS two-bit slot states into one memory row.
  localparam int STATE_W    = 2;
  localparam int ROW_SLOTS  = 16;
  localparam int ROW_SEL_W  = $clog2(ROW_SLOTS);
  localparam int ROW_W      = SLOT_W - ROW_SEL_W;
  localparam int ROWS       = (TASK_SLOTS + ROW_SLOTS - 1) / ROW_SLOTS;
  localparam int ROW_DATA_W = ROW_SLOTS * STATE_W;

  localparam int ATTEMPT_W = $clog2(POP_ATTEMPTS + 1);
  localparam int COUNT_W   = $clog2(TASK_SLOTS + 1);

  // Slot numbers below this limit exist.
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(TASK_SLOTS);

  // Release outcomes; the fourth code is rejected.
  localparam logic [1:0] OUTCOME_YIELD  = 2'd0;
  localparam logic [1:0] OUTCOME_FINISH = 2'd1;
  localparam logic [1:0] OUTCOME_BLOCK  = 2'd2;

  typedef enum logic [1:0] {
    CMD_SUBMIT,
    CMD_ACQUIRE,
    CMD_RELEASE,
    CMD_WAKE
  } command_t;

  typedef enum logic [1:0] {
    SLOT_FREE,
    SLOT_RUNNABLE,
    SLOT_RUNNING,
    SLOT_BLOCKED
  } slot_state_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NONE,
    STATUS_FULL,
    STATUS_WRONG
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB_RD,
    ST_ACQ_POP,
    ST_ACQ_ENT,
    ST_ACQ_CHK,
    ST_CHG_CHK,
    ST_RESP
  } fsm_state_t;

  // Access to the status table: one row read and one row write per cycle.
  typedef struct packed {
    logic                  rd_en;
    logic [ROW_W-1:0]      rd_row;
    logic                  wr_en;
    logic [ROW_W-1:0]      wr_row;
    logic [ROW_DATA_W-1:0] wr_data;
  } table_req_t;

  // Access to the ready ring.
  typedef struct packed {
    logic              push;
    logic [SLOT_W-1:0] push_slot;
    logic              pop;
  } ring_req_t;

  function automatic slot_state_t row_get(input logic [ROW_DATA_W-1:0] data,
                                          input logic [ROW_SEL_W-1:0]  sel);
    return slot_state_t'(data[sel*STATE_W +: STATE_W]);
  endfunction

  function automatic logic [ROW_DATA_W-1:0] row_set(input logic [ROW_DATA_W-1:0] data,
                                                    input logic [ROW_SEL_W-1:0]  sel,
                                                    input slot_state_t           st);
    logic [ROW_DATA_W-1:0] r;
    r = data;
    r[sel*STATE_W +: STATE_W] = st;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/task_slot_scheduler_core.sv
`default_nettype none
// Channel   Handshake                     Payload
// request   request_valid/request_ready   command, slot, outcome
// result    result_valid/result_ready     result_slot, status, live_tasks, all_done
//
// Submit, release and wake pass through one working state to the result
// state, or go straight to it when rejected early (no free slot, slot number
// out of range). Acquire loops through pop, entry and check states, dropping
// stale entries, until a runnable slot is found, the ring is empty or the
// attempt limit is reached. Each entry costs one read of the ready ring memory
// followed by one read of the status row memory.
// No clearing pass after reset: per-row valid bits make unwritten status rows
// read as free, so request_ready is high in the first cycle after reset.
// While a result is held, one new request is taken and worked on; it then
// waits with its result, and request_ready stays low until the held one goes.

module task_slot_scheduler_core import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  logic [1:0]        command,
  input  logic [SLOT_W-1:0] slot,
  input  logic [1:0]        outcome,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [SLOT_W-1:0] result_slot,
  output logic [1:0]        status,
  output logic [LIVE_W-1:0] live_tasks,
  output logic              all_done
);

  fsm_state_t state;
  fsm_state_t state_next;

  // Working registers of the request in progress. slot_q holds the target
  // slot of release and wake, the claimed row of submit, and the popped
  // slot of acquire.
  command_t             cmd_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [1:0]           outcome_q;
  logic [ATTEMPT_W-1:0] attempts;
  logic [LIVE_W-1:0]    live_count;
  logic [SLOT_W-1:0]    res_slot;
  status_t              res_status;

  // Memory interfaces.
  table_req_t            tbl;
  logic [ROW_DATA_W-1:0] tbl_rd_data;
  logic                  free_any;
  logic [ROW_W-1:0]      free_row;
  ring_req_t             rng;
  logic [SLOT_W-1:0]     head_slot;
  logic                  ring_empty;

  // Controls from the output decode.
  logic              accept;
  logic              res_load;
  logic [SLOT_W-1:0] res_slot_next;
  status_t           res_status_next;
  logic              live_inc;
  logic              live_dec;
  logic              attempt_inc;
  logic              slot_from_ring;
  logic              out_load;

  // Decoded views of the current row and request.
  command_t           cmd_in;
  logic               slot_in_range;
  logic               head_in_range;
  logic               can_pop;
  logic [ROW_W-1:0]   cur_row;
  logic [ROW_SEL_W-1:0] cur_sel;
  logic [ROW_SEL_W-1:0] free_sel;
  slot_state_t        entry;

  tss_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl),
    .rd_data (tbl_rd_data),
    .free_any(free_any),
    .free_row(free_row)
  );

  tss_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .req      (rng),
    .head_slot(head_slot),
    .empty    (ring_empty)
  );

  assign request_ready = (state == ST_IDLE);
  assign accept        = request_valid && request_ready;
  assign cmd_in        = command_t'(command);
  assign slot_in_range = ({1'b0, slot} < SLOT_LIMIT);
  assign head_in_range = ({1'b0, head_slot} < SLOT_LIMIT);
  assign can_pop       = !ring_empty && (attempts != ATTEMPT_W'(POP_ATTEMPTS));
  assign cur_row       = slot_q[SLOT_W-1:ROW_SEL_W];
  assign cur_sel       = slot_q[ROW_SEL_W-1:0];
  assign entry         = row_get(tbl_rd_data, cur_sel);
  assign out_load      = (state == ST_RESP) && (!result_valid || result_ready);

  // Lowest free slot of the row that submit has read. The free summary in
  // the table guarantees the row holds at least one.
  always_comb begin
    free_sel = '0;
    for (int i = ROW_SLOTS - 1; i >= 0; i--) begin
      if (row_get(tbl_rd_data, ROW_SEL_W'(i)) == SLOT_FREE &&
          {1'b0, cur_row, ROW_SEL_W'(i)} < SLOT_LIMIT) begin
        free_sel = ROW_SEL_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_SUBMIT:  state_next = free_any ? ST_SUB_RD : ST_RESP;
            CMD_ACQUIRE: state_next = ST_ACQ_POP;
            CMD_RELEASE,
            CMD_WAKE:    state_next = slot_in_range ? ST_CHG_CHK : ST_RESP;
          endcase
        end
      end
      ST_SUB_RD:  state_next = ST_RESP;
      ST_ACQ_POP: state_next = can_pop ? ST_ACQ_ENT : ST_RESP;
      ST_ACQ_ENT: state_next = head_in_range ? ST_ACQ_CHK : ST_ACQ_POP;
      ST_ACQ_CHK: state_next = (entry == SLOT_RUNNABLE) ? ST_RESP : ST_ACQ_POP;
      ST_CHG_CHK: state_next = ST_RESP;
      ST_RESP:    state_next = out_load ? ST_IDLE : ST_RESP;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory accesses and register controls of each state.
  always_comb begin
    tbl             = '0;
    rng             = '0;
    res_load        = 1'b0;
    res_slot_next   = '0;
    res_status_next = STATUS_OK;
    live_inc        = 1'b0;
    live_dec        = 1'b0;
    attempt_inc     = 1'b0;
    slot_from_ring  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_SUBMIT: begin
              if (free_any) begin
                tbl.rd_en  = 1'b1;
                tbl.rd_row = free_row;
              end else begin
                res_load        = 1'b1;
                res_status_next = STATUS_FULL;
              end
            end
            CMD_ACQUIRE: begin
            end
            CMD_RELEASE,
            CMD_WAKE: begin
              if (slot_in_range) begin
                tbl.rd_en  = 1'b1;
                tbl.rd_row = slot[SLOT_W-1:ROW_SEL_W];
              end else begin
                res_load        = 1'b1;
                res_status_next = STATUS_WRONG;
              end
            end
          endcase
        end
      end
      ST_SUB_RD: begin
        tbl.wr_en       = 1'b1;
        tbl.wr_row      = cur_row;
        tbl.wr_data     = row_set(tbl_rd_data, free_sel, SLOT_RUNNABLE);
        rng.push        = 1'b1;
        rng.push_slot   = {cur_row, free_sel};
        live_inc        = 1'b1;
        res_load        = 1'b1;
        res_slot_next   = {cur_row, free_sel};
        res_status_next = STATUS_OK;
      end
      ST_ACQ_POP: begin
        if (can_pop) begin
          rng.pop = 1'b1;
        end else begin
          res_load        = 1'b1;
          res_status_next = STATUS_NONE;
        end
      end
      ST_ACQ_ENT: begin
        slot_from_ring = 1'b1;
        if (head_in_range) begin
          tbl.rd_en  = 1'b1;
          tbl.rd_row = head_slot[SLOT_W-1:ROW_SEL_W];
        end else begin
          attempt_inc = 1'b1;
        end
      end
      ST_ACQ_CHK: begin
        if (entry == SLOT_RUNNABLE) begin
          tbl.wr_en       = 1'b1;
          tbl.wr_row      = cur_row;
          tbl.wr_data     = row_set(tbl_rd_data, cur_sel, SLOT_RUNNING);
          res_load        = 1'b1;
          res_slot_next   = slot_q;
          res_status_next = STATUS_OK;
        end else begin
          attempt_inc = 1'b1;
        end
      end
      ST_CHG_CHK: begin
        res_load        = 1'b1;
        res_status_next = STATUS_OK;
        tbl.wr_row      = cur_row;
        if (cmd_q == CMD_RELEASE) begin
          priority if (entry != SLOT_RUNNING) begin
            res_status_next = STATUS_WRONG;
          end else if (outcome_q == OUTCOME_YIELD) begin
            tbl.wr_en     = 1'b1;
            tbl.wr_data   = row_set(tbl_rd_data, cur_sel, SLOT_RUNNABLE);
            rng.push      = 1'b1;
            rng.push_slot = slot_q;
          end else if (outcome_q == OUTCOME_FINISH) begin
            tbl.wr_en   = 1'b1;
            tbl.wr_data = row_set(tbl_rd_data, cur_sel, SLOT_FREE);
            live_dec    = (live_count != '0);
          end else if (outcome_q == OUTCOME_BLOCK) begin
            tbl.wr_en   = 1'b1;
            tbl.wr_data = row_set(tbl_rd_data, cur_sel, SLOT_BLOCKED);
          end else begin
            res_status_next = STATUS_WRONG;
          end
        end else begin
          if (entry == SLOT_BLOCKED) begin
            tbl.wr_en     = 1'b1;
            tbl.wr_data   = row_set(tbl_rd_data, cur_sel, SLOT_RUNNABLE);
            rng.push      = 1'b1;
            rng.push_slot = slot_q;
          end else begin
            res_status_next = STATUS_WRONG;
          end
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      live_count   <= '0;
      attempts     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (live_inc) begin
        live_count <= live_count + 1'b1;
      end else if (live_dec) begin
        live_count <= live_count - 1'b1;
      end
      if (accept) begin
        attempts <= '0;
      end else if (attempt_inc || (state == ST_ACQ_CHK && entry != SLOT_RUNNABLE)) begin
        attempts <= attempts + 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= cmd_in;
      outcome_q <= outcome;
      slot_q    <= (cmd_in == CMD_SUBMIT) ? {free_row, ROW_SEL_W'(0)} : slot;
    end else if (slot_from_ring) begin
      slot_q <= head_slot;
    end
    if (res_load) begin
      res_slot   <= res_slot_next;
      res_status <= res_status_next;
    end
    if (out_load) begin
      result_slot <= res_slot;
      status      <= res_status;
      live_tasks  <= live_count;
      all_done    <= (live_count == '0);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tss_ram.sv
`default_nettype none

module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tss_slot_table.sv
`default_nettype none

module tss_slot_table import tss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  table_req_t            req,
  output logic [ROW_DATA_W-1:0] rd_data,
  output logic                  free_any,
  output logic [ROW_W-1:0]      free_row
);

  // A row that was never written reads as all free.
  logic [ROWS-1:0]       row_valid;
  logic [ROWS-1:0]       row_has_free;
  logic                  rd_row_valid;
  logic                  wr_has_free;
  logic [ROW_DATA_W-1:0] ram_q;

  tss_ram #(
    .WIDTH(ROW_DATA_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_row),
    .wdata(req.wr_data),
    .re   (req.rd_en),
    .raddr(req.rd_row),
    .rdata(ram_q)
  );

  assign rd_data = rd_row_valid ? ram_q : '0;

  always_comb begin
    wr_has_free = 1'b0;
    for (int i = 0; i < ROW_SLOTS; i++) begin
      if (row_get(req.wr_data, ROW_SEL_W'(i)) == SLOT_FREE &&
          {1'b0, req.wr_row, ROW_SEL_W'(i)} < SLOT_LIMIT) begin
        wr_has_free = 1'b1;
      end
    end
  end

  always_comb begin
    free_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (row_has_free[r]) begin
        free_row = ROW_W'(r);
      end
    end
  end

  assign free_any = |row_has_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      row_has_free <= '1;
      rd_row_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_row]    <= 1'b1;
        row_has_free[req.wr_row] <= wr_has_free;
      end
      if (req.rd_en) begin
        rd_row_valid <= row_valid[req.rd_row];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tss_ring.sv
`default_nettype none

module tss_ring import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ring_req_t         req,
  output logic [SLOT_W-1:0] head_slot,
  output logic              empty
);

  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  tail;
  logic [COUNT_W-1:0] count;
  logic               push_ok;

  // A push onto a full ring is dropped.
  assign push_ok = req.push && (count < COUNT_W'(TASK_SLOTS));
  assign empty   = (count == '0);

  tss_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TASK_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (push_ok),
    .waddr(tail),
    .wdata(req.push_slot),
    .re   (req.pop),
    .raddr(head),
    .rdata(head_slot)
  );

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(TASK_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        tail <= wrap_inc(tail);
      end
      if (req.pop) begin
        head <= wrap_inc(head);
      end
      unique case ({push_ok, req.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tss_checker.sv
`default_nettype none
`include "task_slot_scheduler_core_assert.svh"

module tss_checker import tss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              request_valid,
  input logic              request_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [SLOT_W-1:0] result_slot,
  input logic [1:0]        status,
  input logic [LIVE_W-1:0] live_tasks,
  input logic              all_done
);

  // A request in progress blocks the next one until its result is formed.
  `TSS_ASSERT_NEXT(a_one_at_a_time, request_valid && request_ready, !request_ready)

  // The done flag mirrors the live count it travels with.
  `TSS_ASSERT_SAME(a_done_flag, result_valid, all_done == (live_tasks == '0))

  // Only successful requests carry a slot number.
  `TSS_ASSERT_SAME(a_slot_on_ok, result_valid && (status != STATUS_OK), result_slot == '0)

  // The live count never exceeds the number of slots.
  `TSS_ASSERT_SAME(a_live_bound, result_valid, live_tasks <= LIVE_W'(TASK_SLOTS))

  // A stalled result keeps its payload.
  `TSS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_slot) && $stable(status) && $stable(live_tasks))

endmodule

bind task_slot_scheduler_core tss_checker u_checker (.*);

`default_nettype wire

FILE: bench/slot_sched_checker.sv
// Watches both channels of the scheduler. It keeps its own copy of the slot
// table, the ready FIFO and the live count, and works out the result that
// each accepted request must produce. Results come back in request order, so
// each returned result is checked against the oldest result still awaited.
module slot_sched_checker import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  input  logic              request_ready,
  input  logic [1:0]        command,
  input  logic [SLOT_W-1:0] slot,
  input  logic [1:0]        outcome,
  input  logic              result_valid,
  input  logic              result_ready,
  input  logic [SLOT_W-1:0] result_slot,
  input  logic [1:0]        status,
  input  logic [LIVE_W-1:0] live_tasks,
  input  logic              all_done,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [LIVE_W-1:0] live;
    logic              done;
  } sched_result_t;

  slot_state_t       slot_table [TASK_SLOTS];
  logic [SLOT_W-1:0] ready_fifo [TASK_SLOTS];
  int                fifo_head;
  int                fifo_tail;
  int                fifo_used;
  int                live_count;
  sched_result_t     awaited_results [$];
  sched_result_t     want;

  // A push onto a full FIFO is dropped.
  function automatic void ready_push(logic [SLOT_W-1:0] s);
    if (fifo_used >= TASK_SLOTS) return;
    ready_fifo[fifo_tail] = s;
    fifo_tail = (fifo_tail + 1) % TASK_SLOTS;
    fifo_used++;
  endfunction

  function automatic sched_result_t apply_command(command_t cmd, logic [SLOT_W-1:0] s,
                                                  logic [1:0] oc);
    sched_result_t     r;
    logic [SLOT_W-1:0] popped;
    r.slot   = '0;
    r.status = STATUS_OK;
    case (cmd)
      CMD_SUBMIT: begin
        r.status = STATUS_FULL;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (slot_table[i] == SLOT_FREE) begin
            slot_table[i] = SLOT_RUNNABLE;
            live_count++;
            ready_push(SLOT_W'(i));
            r.slot   = SLOT_W'(i);
            r.status = STATUS_OK;
            break;
          end
        end
      end
      CMD_ACQUIRE: begin
        // Entries that are no longer runnable are dropped on the way.
        r.status = STATUS_NONE;
        for (int n = 0; n < POP_ATTEMPTS; n++) begin
          if (fifo_used == 0) break;
          popped = ready_fifo[fifo_head];
          fifo_head = (fifo_head + 1) % TASK_SLOTS;
          fifo_used--;
          if (int'(popped) < TASK_SLOTS && slot_table[popped] == SLOT_RUNNABLE) begin
            slot_table[popped] = SLOT_RUNNING;
            r.slot   = popped;
            r.status = STATUS_OK;
            break;
          end
        end
      end
      CMD_RELEASE: begin
        if (int'(s) >= TASK_SLOTS || slot_table[s] != SLOT_RUNNING) begin
          r.status = STATUS_WRONG;
        end else begin
          case (oc)
            OUTCOME_YIELD: begin
              slot_table[s] = SLOT_RUNNABLE;
              ready_push(s);
            end
            OUTCOME_FINISH: begin
              slot_table[s] = SLOT_FREE;
              if (live_count > 0) live_count--;
            end
            OUTCOME_BLOCK: slot_table[s] = SLOT_BLOCKED;
            default: r.status = STATUS_WRONG;
          endcase
        end
      end
      default: begin
        if (int'(s) >= TASK_SLOTS || slot_table[s] != SLOT_BLOCKED) begin
          r.status = STATUS_WRONG;
        end else begin
          slot_table[s] = SLOT_RUNNABLE;
          ready_push(s);
        end
      end
    endcase
    r.live = LIVE_W'(live_count);
    r.done = (live_count == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [LIVE_W-1:0] want_v,
                                      logic [LIVE_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_table[i]) slot_table[i] = SLOT_FREE;
      fifo_head   = 0;
      fifo_tail   = 0;
      fifo_used   = 0;
      live_count  = 0;
      mismatches  = 0;
      outstanding = 0;
      awaited_results.delete();
    end else begin
      // The result side is looked at first: a result taken in the same cycle
      // as a request always belongs to an older request.
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %0d status %0d live %0d",
                   $time, result_slot, status, live_tasks);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_slot", want.slot, result_slot);
          check_field("status", want.status, status);
          check_field("live_tasks", want.live, live_tasks);
          check_field("all_done", want.done, all_done);
        end
      end
      if (request_valid && request_ready)
        awaited_results.push_back(apply_command(command_t'(command), slot, outcome));
      outstanding = awaited_results.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the scheduler bench. This module only makes stimulus and gives the
// verdict; the checker instance beside the block does all prediction and
// comparison and reports its mismatch count and the number of results it is
// still waiting for.
module testbench import tss_pkg::*;;

  // The fourth release outcome code has no meaning and must be rejected.
  localparam logic [1:0] OUTCOME_BAD = 2'd3;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG_STALL
  } rx_mode_t;

  typedef struct {
    command_t          cmd;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        oc;
  } sent_request_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              request_valid = 1'b0;
  logic              request_ready;
  logic [1:0]        command = CMD_SUBMIT;
  logic [SLOT_W-1:0] slot = '0;
  logic [1:0]        outcome = OUTCOME_YIELD;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [SLOT_W-1:0] result_slot;
  logic [1:0]        status;
  logic [LIVE_W-1:0] live_tasks;
  logic              all_done;
  int                mismatches;
  int                outstanding;

  // Slots that the bench believes to be running or blocked. These are only
  // hints for building well-formed request sequences; they are learned from
  // returned results and are never used for checking.
  int            running_pool [$];
  int            blocked_pool [$];
  sent_request_t in_flight [$];
  sent_request_t answered;

  int       items;
  int       burst_left;
  int       full_seen;
  int       peak_live;
  int       cmd_seen [4];
  int       status_seen [4];
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_stall_left;
  int       rx_tick;

  task_slot_scheduler_core i_dut (.*);

  slot_sched_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never comes back.
  initial begin
    #(12 * 2000000);
    $display("%0t: timeout with %0d results still awaited", $time, outstanding);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver side. The stall behavior switches at random among always ready,
  // a coin toss, a fixed one-in-four pattern and long stalls, so that held
  // results land on every phase of the block's work.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     result_ready <= 1'b1;
      RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: result_ready <= (rx_tick % 4 == 3);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          result_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          rx_stall_left = $urandom_range(1, 12);
          result_ready <= 1'b0;
        end else begin
          result_ready <= 1'b1;
        end
      end
    endcase
  end

  // Keeps the stimulus hints and the coverage tallies in step with the
  // channels. Results return in request order, so the oldest request in
  // flight is the one each result answers.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready && in_flight.size() > 0) begin
        answered = in_flight.pop_front();
        status_seen[status]++;
        if (live_tasks > peak_live) peak_live = live_tasks;
        if (status == STATUS_FULL) full_seen++;
        if (status == STATUS_OK) begin
          if (answered.cmd == CMD_ACQUIRE)
            running_pool.push_back(result_slot);
          else if (answered.cmd == CMD_RELEASE && answered.oc == OUTCOME_BLOCK)
            blocked_pool.push_back(answered.slot);
        end
      end
      if (request_valid && request_ready) begin
        in_flight.push_back('{command_t'(command), slot, outcome});
        cmd_seen[command]++;
      end
    end
  end

  // Presents one request and holds it until the block takes it. Requests go
  // out in bursts; between bursts valid drops for a random gap, which is
  // sometimes long. Long bursts give stretches with no sender idling at all.
  task automatic send_request(command_t c, logic [SLOT_W-1:0] s, logic [1:0] oc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        request_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    request_valid <= 1'b1;
    command       <= c;
    slot          <= s;
    outcome       <= oc;
    @(posedge clk);
    while (!request_ready) @(posedge clk);
    items++;
    @(negedge clk);
  endtask

  // Stops sending until every awaited result has come back.
  task automatic wait_drained();
    request_valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Builds one random request. The weights are percentages for submit,
  // acquire, release and wake; whatever is left over is pure noise with a
  // random command, slot and outcome. Releases and wakes mostly target slots
  // known to be running or blocked, so that they actually change state.
  task automatic issue_random(int w_sub, int w_acq, int w_rel, int w_wake, int pct_finish);
    int                roll;
    int                idx;
    command_t          c;
    logic [SLOT_W-1:0] s;
    logic [1:0]        oc;
    roll = $urandom_range(0, 99);
    c    = command_t'($urandom_range(0, 3));
    s    = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
    oc   = 2'($urandom_range(0, 3));
    if (roll < w_sub) begin
      c = CMD_SUBMIT;
    end else if (roll < w_sub + w_acq) begin
      c = CMD_ACQUIRE;
    end else if (roll < w_sub + w_acq + w_rel) begin
      c = CMD_RELEASE;
      if ($urandom_range(0, 99) < pct_finish)
        oc = OUTCOME_FINISH;
      else if ($urandom_range(0, 19) == 0)
        oc = OUTCOME_BAD;
      else
        oc = 2'($urandom_range(0, 2));
      if (running_pool.size() > 0) begin
        idx = $urandom_range(0, running_pool.size() - 1);
        s   = SLOT_W'(running_pool[idx]);
        // A rejected outcome leaves the slot running, so it stays a candidate.
        if (oc != OUTCOME_BAD) running_pool.delete(idx);
      end
    end else if (roll < w_sub + w_acq + w_rel + w_wake) begin
      c = CMD_WAKE;
      if (blocked_pool.size() > 0) begin
        idx = $urandom_range(0, blocked_pool.size() - 1);
        s   = SLOT_W'(blocked_pool[idx]);
        blocked_pool.delete(idx);
      end
    end
    send_request(c, s, oc);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening. Slot numbers here follow from the lowest-free-slot
    // rule starting at an empty scheduler.
    send_request(CMD_ACQUIRE, 0, OUTCOME_YIELD);       // empty queue
    send_request(CMD_RELEASE, 0, OUTCOME_FINISH);      // slot is free
    send_request(CMD_WAKE, SLOT_W'(TASK_SLOTS - 1), OUTCOME_BLOCK);
    send_request(CMD_RELEASE, SLOT_W'(TASK_SLOTS - 1), OUTCOME_BAD);
    send_request(CMD_SUBMIT, SLOT_W'(TASK_SLOTS - 1), OUTCOME_BAD);
    send_request(CMD_SUBMIT, 0, OUTCOME_YIELD);
    send_request(CMD_SUBMIT, 0, OUTCOME_YIELD);
    send_request(CMD_ACQUIRE, SLOT_W'(TASK_SLOTS - 1), OUTCOME_BAD);
    send_request(CMD_ACQUIRE, 0, OUTCOME_YIELD);
    send_request(CMD_RELEASE, 0, OUTCOME_BAD);         // unknown outcome, stays running
    send_request(CMD_RELEASE, 0, OUTCOME_YIELD);       // requeued behind slot 2
    send_request(CMD_RELEASE, 1, OUTCOME_BLOCK);
    send_request(CMD_WAKE, 1, OUTCOME_YIELD);
    send_request(CMD_WAKE, 1, OUTCOME_YIELD);          // no longer blocked
    send_request(CMD_ACQUIRE, 0, OUTCOME_YIELD);
    send_request(CMD_RELEASE, 2, OUTCOME_FINISH);
    send_request(CMD_RELEASE, 2, OUTCOME_FINISH);      // already free
    send_request(CMD_ACQUIRE, 0, OUTCOME_YIELD);
    send_request(CMD_ACQUIRE, 0, OUTCOME_YIELD);
    send_request(CMD_ACQUIRE, 0, OUTCOME_YIELD);       // queue empty again
    send_request(CMD_RELEASE, 0, OUTCOME_FINISH);
    send_request(CMD_RELEASE, 1, OUTCOME_FINISH);      // live count back to zero
    send_request(CMD_SUBMIT, 0, OUTCOME_YIELD);        // reuses the lowest slot

    // Let everything settle, then forget the hints gathered so far since the
    // directed slots were freed behind the hint lists' back.
    wait_drained();
    running_pool.delete();
    blocked_pool.delete();

    // Mixed traffic at moderate occupancy.
    while (items < 380) issue_random(25, 30, 30, 8, 35);
    wait_drained();

    // Fill the scheduler until submits are refused several times, which also
    // drives the live count and the slot numbers up to their top bits.
    while (full_seen < 4 && items < 1400) issue_random(88, 6, 3, 1, 0);
    wait_drained();

    // Drain: mostly acquire and finish, with yields and blocks mixed in.
    while (items < 1850) issue_random(10, 40, 42, 5, 70);

    wait_drained();
    // Every awaited result is back; give the block time to show any stray
    // result.
    repeat (64) @(negedge clk);

    $display("Sent %0d requests: %0d submit, %0d acquire, %0d release, %0d wake.",
             items, cmd_seen[CMD_SUBMIT], cmd_seen[CMD_ACQUIRE],
             cmd_seen[CMD_RELEASE], cmd_seen[CMD_WAKE]);
    $display("Statuses: ok %0d, nothing runnable %0d, no free slot %0d, wrong state %0d; %s %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_NONE], status_seen[STATUS_FULL],
             status_seen[STATUS_WRONG], "peak live count", peak_live);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
